FILE: rtl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
// No dependencies.
package pds_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE   = 3'd0,
    REG_MAX_SYS  = 3'd1,
    REG_PIN_LOW  = 3'd2,
    REG_PIN_HIGH = 3'd3,
    REG_N_LOW    = 3'd4,
    REG_N_HIGH   = 3'd5,
    REG_VCO_LOW  = 3'd6,
    REG_VCO_HIGH = 3'd7
  } cfg_reg_e;

  localparam logic [31:0] ErrStart = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    DIV_PIN = 2'd0,
    DIV_N   = 2'd1,
    DIV_ACT = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     init;
    logic     div_start;
    div_sel_e div_sel;
    logic     eval_pin;
    logic     eval_n;
    logic     eval_act;
    logic     mul_pin_n;
    logic     mul_tp;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic too_high;
    logic pin_ok;
    logic n_ok;
    logic vco_ok;
    logic exact;
    logic found;
  } dp_status_t;

endpackage

FILE: rtl/pll_divider_search.sv
// PLL divider search: one result word per request word after a search of
// M over [M_LOW, M_HIGH] and P in steps of two from P_LOW up to P_HIGH, all
// through one shared divider. Each M takes a PLL input division, then each
// P trial an N division and an output division; a trial is cut short when
// it fails its N or VCO limits, and an exact match ends the search early.
// Depends on pds_pkg, pds_ctrl, pds_datapath.
module pll_divider_search import pds_pkg::*; #(
  parameter int unsigned M_LOW  = 2,
  parameter int unsigned M_HIGH = 63,
  parameter int unsigned P_LOW  = 2,
  parameter int unsigned P_HIGH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // target_hz, tolerance_hz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // status, divider_m, multiplier_n, divider_p, out_hz
);
  dp_cmd_t    cmd;
  dp_status_t sts;
  logic [5:0] m, bm;
  logic [3:0] p, bp;
  logic [8:0] bn;
  logic [31:0] ba;
  logic       err;

  assign cfg_ready_o = 1'b1;

  pds_ctrl #(.MLow(M_LOW), .MHigh(M_HIGH), .PLow(P_LOW), .PHigh(P_HIGH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_err_o(err),
    .m_o(m), .p_o(p), .cmd_o(cmd), .sts_i(sts)
  );

  pds_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .load_i(s_axis_tvalid && s_axis_tready),
    .target_i(s_axis_tdata[31:0]), .tol_i(s_axis_tdata[63:32]),
    .m_i(m), .p_i(p), .cmd_i(cmd), .sts_o(sts),
    .best_m_o(bm), .best_n_o(bn), .best_p_o(bp), .best_act_o(ba)
  );

  assign m_axis_tdata = err ? 56'd1 : {4'd0, ba, bp, bn, bm, 1'b0};
endmodule

FILE: rtl/pds_divider.sv
// 32-bit restoring divider, one quotient bit per cycle.
// Uses no package items.
module pds_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    den_d = den_q;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = 6'd32; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0]; quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]}; quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: rtl/pds_datapath.sv
// Datapath: config registers, trial arithmetic, best-divider tracking.
// Depends on pds_pkg and pds_divider.
module pds_datapath import pds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        load_i,
  input  logic [31:0] target_i,
  input  logic [31:0] tol_i,
  input  logic [5:0]  m_i,
  input  logic [3:0]  p_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  sts_o,
  output logic [5:0]  best_m_o,
  output logic [8:0]  best_n_o,
  output logic [3:0]  best_p_o,
  output logic [31:0] best_act_o
);
  logic [31:0] src_q, maxs_q, pinl_q, pinh_q, vcol_q, vcoh_q;
  logic [8:0]  nl_q, nh_q;
  logic [31:0] tgt_q, tol_q, pin_q, n_q, prod_q, best_err_q, best_act_q;
  logic [5:0]  best_m_q;
  logic [8:0]  best_n_q;
  logic [3:0]  best_p_q;
  logic        pin_ok_q, n_ok_q, vco_ok_q, exact_q, found_q;
  logic [31:0] num, den, quo, err;
  logic        ddone;
  logic [63:0] mprod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= 32'd16000000; maxs_q <= 32'd168000000; pinl_q <= 32'd1000000;
      pinh_q <= 32'd2000000; nl_q <= 9'd50; nh_q <= 9'd432;
      vcol_q <= 32'd100000000; vcoh_q <= 32'd432000000;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE:   src_q  <= cfg_data_i;
        REG_MAX_SYS:  maxs_q <= cfg_data_i;
        REG_PIN_LOW:  pinl_q <= cfg_data_i;
        REG_PIN_HIGH: pinh_q <= cfg_data_i;
        REG_N_LOW:    nl_q   <= cfg_data_i[8:0];
        REG_N_HIGH:   nh_q   <= cfg_data_i[8:0];
        REG_VCO_LOW:  vcol_q <= cfg_data_i;
        REG_VCO_HIGH: vcoh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_PIN: begin num = src_q;  den = {26'd0, m_i}; end
      DIV_N:   begin num = prod_q; den = pin_q; end
      DIV_ACT: begin num = prod_q; den = {28'd0, p_i}; end
      default: begin num = prod_q; den = pin_q; end
    endcase
  end

  pds_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num), .den_i(den),
    .done_o(ddone), .quo_o(quo)
  );

  assign mprod = cmd_i.mul_tp ? tgt_q * {28'd0, p_i} : pin_q * n_q;
  assign err = (quo > tgt_q) ? quo - tgt_q : tgt_q - quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0; exact_q <= 1'b0; pin_ok_q <= 1'b0; n_ok_q <= 1'b0;
      vco_ok_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        found_q <= 1'b0; exact_q <= 1'b0;
      end
      if (cmd_i.eval_pin)
        pin_ok_q <= quo != '0 && quo >= pinl_q && quo <= pinh_q;
      if (cmd_i.eval_n)
        n_ok_q <= quo >= {23'd0, nl_q} && quo <= {23'd0, nh_q};
      if (cmd_i.mul_pin_n)
        vco_ok_q <= mprod[31:0] >= vcol_q && mprod[31:0] <= vcoh_q;
      if (cmd_i.eval_act && err < best_err_q && err <= tol_q) begin
        found_q <= 1'b1;
        if (err == '0) exact_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tgt_q <= target_i; tol_q <= tol_i;
    end
    if (cmd_i.init) best_err_q <= ErrStart;
    if (cmd_i.eval_pin) pin_q <= quo;
    if (cmd_i.eval_n) n_q <= quo;
    if (cmd_i.mul_tp || cmd_i.mul_pin_n) prod_q <= mprod[31:0];
    if (cmd_i.eval_act && err < best_err_q && err <= tol_q) begin
      best_err_q <= err; best_act_q <= quo; best_m_q <= m_i;
      best_n_q <= n_q[8:0]; best_p_q <= p_i;
    end
  end

  assign sts_o.div_done = ddone;
  assign sts_o.too_high = tgt_q > maxs_q;
  assign sts_o.pin_ok   = pin_ok_q;
  assign sts_o.n_ok     = n_ok_q;
  assign sts_o.vco_ok   = vco_ok_q;
  assign sts_o.exact    = exact_q;
  assign sts_o.found    = found_q;
  assign best_m_o   = best_m_q;
  assign best_n_o   = best_n_q;
  assign best_p_o   = best_p_q;
  assign best_act_o = best_act_q;
endmodule

FILE: rtl/pds_ctrl.sv
// Search sequencer: walks M and P and issues datapath commands.
// Depends on pds_pkg.
module pds_ctrl import pds_pkg::*; #(
  parameter int unsigned MLow  = 2,
  parameter int unsigned MHigh = 63,
  parameter int unsigned PLow  = 2,
  parameter int unsigned PHigh = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_err_o,
  output logic [5:0] m_o,
  output logic [3:0] p_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t sts_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MSTART, S_MWAIT, S_PCHK, S_TP, S_NSTART, S_NWAIT, S_NCHK,
    S_VCO, S_VCHK, S_AWAIT, S_NEXTP, S_NEXTM, S_DONE
  } state_e;

  state_e     st_q;
  logic [6:0] m_q;
  logic [4:0] p_q;
  logic       err_q;

  assign in_ready_o  = st_q == S_IDLE;
  assign out_valid_o = st_q == S_DONE;
  assign out_err_o   = err_q;
  assign m_o = m_q[5:0];
  assign p_o = p_q[3:0];

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_PIN;
    unique case (st_q)
      S_IDLE:   cmd_o.init = in_valid_i;
      S_MSTART: cmd_o.div_start = 1'b1;
      S_MWAIT:  cmd_o.eval_pin = sts_i.div_done;
      S_TP:     cmd_o.mul_tp = 1'b1;
      S_NSTART: begin cmd_o.div_sel = DIV_N; cmd_o.div_start = 1'b1; end
      S_NWAIT:  begin cmd_o.div_sel = DIV_N; cmd_o.eval_n = sts_i.div_done; end
      S_VCO:    cmd_o.mul_pin_n = 1'b1;
      S_VCHK:   begin cmd_o.div_sel = DIV_ACT; cmd_o.div_start = sts_i.vco_ok; end
      S_AWAIT:  begin cmd_o.div_sel = DIV_ACT; cmd_o.eval_act = sts_i.div_done; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; m_q <= '0; p_q <= '0; err_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: if (in_valid_i) st_q <= S_CHECK;
        S_CHECK: begin
          m_q <= 7'(MLow); err_q <= 1'b0;
          if (sts_i.too_high) begin
            err_q <= 1'b1; st_q <= S_DONE;
          end else if (MLow > MHigh) begin
            err_q <= 1'b1; st_q <= S_DONE;
          end else st_q <= (MLow == 0) ? S_NEXTM : S_MSTART;
        end
        S_MSTART: st_q <= S_MWAIT;
        S_MWAIT: if (sts_i.div_done) st_q <= S_PCHK;
        S_PCHK: begin
          p_q <= 5'(PLow);
          st_q <= (sts_i.pin_ok && PLow <= PHigh) ? S_TP : S_NEXTM;
        end
        S_TP: st_q <= S_NSTART;
        S_NSTART: st_q <= S_NWAIT;
        S_NWAIT: if (sts_i.div_done) st_q <= S_NCHK;
        S_NCHK: st_q <= sts_i.n_ok ? S_VCO : S_NEXTP;
        S_VCO: st_q <= S_VCHK;
        S_VCHK: st_q <= sts_i.vco_ok ? S_AWAIT : S_NEXTP;
        S_AWAIT: if (sts_i.div_done) st_q <= S_NEXTP;
        S_NEXTP: begin
          if (sts_i.exact) st_q <= S_NEXTM;
          else if (p_q + 5'd2 > 5'(PHigh)) st_q <= S_NEXTM;
          else begin p_q <= p_q + 5'd2; st_q <= S_TP; end
        end
        S_NEXTM: begin
          if (sts_i.exact || m_q >= 7'(MHigh)) begin
            err_q <= !sts_i.found; st_q <= S_DONE;
          end else begin
            m_q <= m_q + 7'd1; st_q <= S_MSTART;
          end
        end
        S_DONE: if (out_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/pll_divider_search_checker.sv
// Port-level checks for pll_divider_search, bound to the top level.
// No dependencies.
module pll_divider_search_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[55:1] == 0)
    else $error("error word not cleared");
  a_not_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("no search time");
endmodule

bind pll_divider_search pll_divider_search_checker u_chk (.*);
